/* hw/rtl/cfp_pkg.sv */
// Package: shared types, constants and the CRC byte update for the frame parser.
`timescale 1ns / 1ps

package cfp_pkg;

    localparam logic [7:0]  SYNC_FIRST  = 8'h55;
    localparam logic [7:0]  SYNC_SECOND = 8'hAA;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_SEED    = 16'hFFFF;
    localparam logic [15:0] CRC_TOP     = 16'h8000;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

    // header byte positions; the sync bytes 0 and 1 are matched, not stored
    typedef logic [3:0] hdr_idx_t;
    localparam hdr_idx_t HDR_FIRST = 4'd2;
    localparam hdr_idx_t HDR_LAST  = 4'd15;
    localparam hdr_idx_t CRC_SPAN  = 4'd14;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic        frame_done;
        logic        crc_ok;
        logic        too_long;
        logic [7:0]  version;
        logic [7:0]  msg_type;
        logic [7:0]  msg_flags;
        logic [15:0] session_tag;
        logic [31:0] sequence_res;
        logic [15:0] payload_length;
    } cfp_result_t;

    // CRC16-CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_TOP) != 16'h0000)
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* hw/rtl/cfp_parser.sv */
// Parser: sync hunt, header capture, running CRC and per-word result build.
`timescale 1ns / 1ps

module cfp_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           data,
    input  logic [15:0]          max_payload,
    output logic                 has_result,
    output cfp_pkg::cfp_result_t result
);
    import cfp_pkg::*;

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_SYNC2,
        ST_HEADER,
        ST_PAYLOAD
    } state_t;

    state_t      state_reg, state_next;
    hdr_idx_t    hdr_cnt_reg, hdr_cnt_next;
    logic [15:0] pay_cnt_reg, pay_cnt_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  hdr_reg [HDR_FIRST:HDR_LAST];
    logic        hdr_we;
    logic [15:0] hdr_len;
    logic [15:0] hdr_chk;
    logic [15:0] crc_upd;

    assign hdr_len = {hdr_reg[13], hdr_reg[12]};
    assign hdr_chk = {hdr_reg[15], hdr_reg[14]};
    assign crc_upd = crc16_byte(crc_reg, data);

    always_comb
    begin
        state_next   = state_reg;
        hdr_cnt_next = hdr_cnt_reg;
        pay_cnt_next = pay_cnt_reg;
        crc_next     = crc_reg;
        hdr_we       = 1'b0;
        has_result   = 1'b0;
        result       = '0;
        unique case (state_reg)
            ST_HUNT:
            begin
                if (data == SYNC_FIRST)
                begin
                    crc_next   = crc16_byte(CRC_SEED, data);
                    state_next = ST_SYNC2;
                end
            end
            ST_SYNC2:
            begin
                if (data == SYNC_SECOND)
                begin
                    crc_next     = crc_upd;
                    hdr_cnt_next = HDR_FIRST;
                    state_next   = ST_HEADER;
                end
                else
                begin
                    state_next = ST_HUNT;
                end
            end
            ST_HEADER:
            begin
                hdr_we       = 1'b1;
                hdr_cnt_next = hdr_cnt_reg + 4'd1;
                if (hdr_cnt_reg < CRC_SPAN)
                begin
                    crc_next = crc_upd;
                end
                if (hdr_cnt_reg == HDR_LAST)
                begin
                    // current word is the checksum high byte
                    if (hdr_len > max_payload)
                    begin
                        state_next        = ST_HUNT;
                        has_result        = 1'b1;
                        result.frame_done = 1'b1;
                        result.too_long   = 1'b1;
                    end
                    else if (hdr_len == 16'd0)
                    begin
                        state_next        = ST_HUNT;
                        has_result        = 1'b1;
                        result.frame_done = 1'b1;
                        result.crc_ok     = (crc_reg == {data, hdr_reg[14]});
                    end
                    else
                    begin
                        pay_cnt_next = 16'd0;
                        state_next   = ST_PAYLOAD;
                    end
                end
            end
            ST_PAYLOAD:
            begin
                crc_next             = crc_upd;
                pay_cnt_next         = pay_cnt_reg + 16'd1;
                has_result           = 1'b1;
                result.payload_valid = 1'b1;
                result.payload_byte  = data;
                result.payload_index = pay_cnt_reg;
                if (pay_cnt_next == hdr_len)
                begin
                    state_next        = ST_HUNT;
                    result.frame_done = 1'b1;
                    result.crc_ok     = (crc_upd == hdr_chk);
                end
            end
        endcase
        if (result.frame_done)
        begin
            result.version        = hdr_reg[2];
            result.msg_type       = hdr_reg[3];
            result.msg_flags      = hdr_reg[4];
            result.session_tag    = {hdr_reg[7], hdr_reg[6]};
            result.sequence_res   = {hdr_reg[11], hdr_reg[10], hdr_reg[9], hdr_reg[8]};
            result.payload_length = hdr_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_HUNT;
            hdr_cnt_reg <= '0;
            pay_cnt_reg <= '0;
            crc_reg     <= CRC_SEED;
        end
        else if (step)
        begin
            state_reg   <= state_next;
            hdr_cnt_reg <= hdr_cnt_next;
            pay_cnt_reg <= pay_cnt_next;
            crc_reg     <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && hdr_we)
        begin
            hdr_reg[hdr_cnt_reg] <= data;
        end
    end

`ifndef SYNTHESIS
    a_payload_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (step && state_reg == ST_PAYLOAD) |-> (has_result && result.payload_valid))
        else $error("payload word without result");

    a_abandon_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (step && has_result && result.too_long) |=> (state_reg == ST_HUNT))
        else $error("abandoned frame did not return to hunt");

    a_header_end_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (step && state_reg == ST_HEADER && hdr_cnt_reg == HDR_LAST && !has_result)
        |=> (state_reg == ST_PAYLOAD && pay_cnt_reg == 16'd0))
        else $error("header end did not enter payload");
`endif

endmodule

/* hw/rtl/cfp_out_stage.sv */
// Output register: holds one result word until the consumer takes it.
`timescale 1ns / 1ps

module cfp_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  cfp_pkg::cfp_result_t res_in,
    input  logic                 out_ready,
    output logic                 out_valid,
    output cfp_pkg::cfp_result_t res_out
);
    import cfp_pkg::*;

    logic        valid_reg, valid_next;
    cfp_result_t res_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

/* hw/rtl/crc16_frame_parser_core.sv */
// Top level: input register, limit register, parser and output register.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  input   | in_valid, in_ready, rx_byte      | in
//  config  | cfg_we, cfg_wdata (max_payload)  | in
//  result  | out_valid, out_ready, fields     | out
//
// One byte per cycle while results are taken; the CRC byte update and state
// step are combinational between the input register and the output register.
// A byte that yields a result loads the output register, which sets out_valid.
// Reset puts the parser in sync hunt, CRC at seed, max_payload at 1024.
// A stalled result holds the input register; in_ready drops once both are full.
`timescale 1ns / 1ps

module crc16_frame_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        payload_valid,
    output logic [7:0]  payload_byte,
    output logic [15:0] payload_index,
    output logic        frame_done,
    output logic        crc_ok,
    output logic        too_long,
    output logic [7:0]  version,
    output logic [7:0]  msg_type,
    output logic [7:0]  msg_flags,
    output logic [15:0] session_tag,
    output logic [31:0] sequence_res,
    output logic [15:0] payload_length
);
    import cfp_pkg::*;

    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic [15:0] max_payload_reg;
    logic        advance;
    logic        in_take;
    logic        has_result;
    cfp_result_t res_new;
    cfp_result_t res_out;

    assign advance  = s1_valid_reg && (!out_valid || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (cfg_we)
            begin
                max_payload_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    cfp_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .data        (s1_byte_reg),
        .max_payload (max_payload_reg),
        .has_result  (has_result),
        .result      (res_new)
    );

    cfp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && has_result),
        .res_in    (res_new),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .res_out   (res_out)
    );

    assign payload_valid  = res_out.payload_valid;
    assign payload_byte   = res_out.payload_byte;
    assign payload_index  = res_out.payload_index;
    assign frame_done     = res_out.frame_done;
    assign crc_ok         = res_out.crc_ok;
    assign too_long       = res_out.too_long;
    assign version        = res_out.version;
    assign msg_type       = res_out.msg_type;
    assign msg_flags      = res_out.msg_flags;
    assign session_tag    = res_out.session_tag;
    assign sequence_res   = res_out.sequence_res;
    assign payload_length = res_out.payload_length;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid && !out_ready))
        else $error("input stalled with room downstream");

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> s1_valid_reg)
        else $error("accepted word lost from input register");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_byte_reg)))
        else $error("held word changed in input register");
`endif

endmodule
